// ===== rtl/core/plc_pkg.sv =====
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types and constants of the palette colour lookup core.
// ----------------------------------------------------------------------------
package plc_pkg;

   // transaction kinds on the request channel
   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_LOOKUP = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;

   // pixel formats
   localparam logic [1:0] FMT_PAL8   = 2'd0;
   localparam logic [1:0] FMT_RGB565 = 2'd1;
   localparam logic [1:0] FMT_RGB555 = 2'd2;
   localparam logic [1:0] FMT_XRGB32 = 2'd3;

   // flag byte in the top of a palettized word
   localparam logic [7:0] PAL8_FLAG = 8'h04;

   // configuration register indexes
   localparam logic [1:0] CSR_PIXEL_FORMAT = 2'd0;
   localparam logic [1:0] CSR_GRAYSCALE    = 2'd1;

   // how the registered read word turns into the response value
   typedef enum logic [1:0] {
      RSP_SEL_INDEX = 2'd0,
      RSP_SEL_LOW16 = 2'd1,
      RSP_SEL_WORD  = 2'd2,
      RSP_SEL_ZERO  = 2'd3
   } rsp_sel_type;

   // write port of the palette memory
   typedef struct packed {
      logic        en;
      logic [7:0]  addr;
      logic [31:0] data;
   } mem_wr_type;

endpackage

// ===== rtl/core/plc_pack.sv =====
// ----------------------------------------------------------------------------
// plc_pack
// Scales a 6-bit colour to 8 bits, optionally converts it to grey and packs
// it into the selected pixel format.
// ----------------------------------------------------------------------------
module plc_pack (
   input  logic [1:0]  pixel_format,
   input  logic        grayscale_enable,
   input  logic [5:0]  red,
   input  logic [5:0]  green,
   input  logic [5:0]  blue,
   output logic [31:0] packed_word
);

   logic [7:0]  r8;
   logic [7:0]  g8;
   logic [7:0]  b8;
   logic [11:0] luma_sum;
   logic [7:0]  luma;
   logic [7:0]  r_sel;
   logic [7:0]  g_sel;
   logic [7:0]  b_sel;

   // scale to 8 bits
   assign r8 = {red, 2'b00};
   assign g8 = {green, 2'b00};
   assign b8 = {blue, 2'b00};

   // weighted grey, 6r + 8g + 2b over 16
   assign luma_sum = 12'({r8, 2'b00}) + 12'({r8, 1'b0}) + 12'({g8, 3'b000})
                     + 12'({b8, 1'b0});
   assign luma     = luma_sum[11:4];

   assign r_sel = grayscale_enable ? luma : r8;
   assign g_sel = grayscale_enable ? luma : g8;
   assign b_sel = grayscale_enable ? luma : b8;

   // pack into the current format
   always_comb begin
      case (pixel_format)
         plc_pkg::FMT_PAL8: begin
            packed_word = {plc_pkg::PAL8_FLAG, b_sel, g_sel, r_sel};
         end
         plc_pkg::FMT_RGB565: begin
            packed_word = {16'h0000, r_sel[7:3], g_sel[7:2], b_sel[7:3]};
         end
         plc_pkg::FMT_RGB555: begin
            packed_word = {16'h0000, 1'b0, r_sel[7:3], g_sel[7:3], b_sel[7:3]};
         end
         default: begin
            packed_word = {8'h00, r_sel, g_sel, b_sel};
         end
      endcase
   end

endmodule

// ===== rtl/core/plc_ram.sv =====
// ----------------------------------------------------------------------------
// plc_ram
// Palette store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module plc_ram #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic               clock,
   input  plc_pkg::mem_wr_type wr,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [31:0]        rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[ADDR_W-1:0]] <= wr.data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/palette_color_lookup_core.sv =====
// ----------------------------------------------------------------------------
// palette_color_lookup_core
// Colour palette with packing on write and lookup or read back on request.
//
//   channel   ports                          direction  handshake
//   request   start busy req_*               in         start && !busy
//   response  rsp_valid rsp_value            out        strobe, one cycle
//   config    csr_valid csr_ready csr_*      in         csr_valid && csr_ready
//
// One transaction is taken every clock; busy stays low.
// A lookup or read answers in the cycle after acceptance, through the registered
// read port of the palette memory; a write gives no response.
// A write is visible to a request accepted in the next cycle.
// Synchronous reset clears the strobe and the configuration; the palette is
// not cleared. The receiver cannot stall the response.
// ----------------------------------------------------------------------------
module palette_color_lookup_core #(
   parameter int ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_index,
   input  logic [5:0]  req_red,
   input  logic [5:0]  req_green,
   input  logic [5:0]  req_blue,
   output logic        rsp_valid,
   output logic [31:0] rsp_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic                 accept;
   logic                 in_range;
   logic [31:0]          packed_word;
   logic [31:0]          rd_data;
   plc_pkg::mem_wr_type  mem_wr;
   logic                 rd_en;

   logic [1:0]           fmt_ff;
   logic                 gray_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   plc_pkg::rsp_sel_type sel_ff;
   plc_pkg::rsp_sel_type sel_in;
   logic [7:0]           index_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign in_range  = 32'(req_index) < ENTRIES;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff  <= plc_pkg::FMT_PAL8;
         gray_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == plc_pkg::CSR_PIXEL_FORMAT) begin
            fmt_ff <= csr_data[1:0];
         end else if (csr_index == plc_pkg::CSR_GRAYSCALE) begin
            gray_ff <= csr_data[0];
         end
      end
   end

   // colour packing for writes
   plc_pack u_pack (
      .pixel_format    (fmt_ff),
      .grayscale_enable(gray_ff),
      .red             (req_red),
      .green           (req_green),
      .blue            (req_blue),
      .packed_word     (packed_word)
   );

   // memory access
   always_comb begin
      mem_wr.en   = accept && (req_kind == plc_pkg::KIND_WRITE) && in_range;
      mem_wr.addr = req_index;
      mem_wr.data = packed_word;
      rd_en       = accept && in_range
                    && ((req_kind == plc_pkg::KIND_LOOKUP) || (req_kind == plc_pkg::KIND_READ));
   end

   plc_ram #(
      .DEPTH (ENTRIES),
      .ADDR_W(ADDR_W)
   ) u_ram (
      .clock  (clock),
      .wr     (mem_wr),
      .rd_en  (rd_en),
      .rd_addr(req_index[ADDR_W-1:0]),
      .rd_data(rd_data)
   );

   // response selection decided at acceptance
   always_comb begin
      rsp_valid_in = 1'b0;
      sel_in       = plc_pkg::RSP_SEL_ZERO;
      if (accept) begin
         case (req_kind)
            plc_pkg::KIND_LOOKUP: begin
               rsp_valid_in = 1'b1;
               if (fmt_ff == plc_pkg::FMT_PAL8) begin
                  sel_in = plc_pkg::RSP_SEL_INDEX;
               end else if (!in_range) begin
                  sel_in = plc_pkg::RSP_SEL_ZERO;
               end else if (fmt_ff == plc_pkg::FMT_XRGB32) begin
                  sel_in = plc_pkg::RSP_SEL_WORD;
               end else begin
                  sel_in = plc_pkg::RSP_SEL_LOW16;
               end
            end
            plc_pkg::KIND_READ: begin
               rsp_valid_in = 1'b1;
               sel_in       = in_range ? plc_pkg::RSP_SEL_WORD : plc_pkg::RSP_SEL_ZERO;
            end
            default: begin
               rsp_valid_in = 1'b0;
            end
         endcase
      end
   end

   // response stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sel_ff   <= sel_in;
         index_ff <= req_index;
      end
   end

   // response value
   always_comb begin
      case (sel_ff)
         plc_pkg::RSP_SEL_INDEX: rsp_value = {24'h000000, index_ff};
         plc_pkg::RSP_SEL_LOW16: rsp_value = {16'h0000, rd_data[15:0]};
         plc_pkg::RSP_SEL_WORD:  rsp_value = rd_data;
         default:                rsp_value = 32'h00000000;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   // checks
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == plc_pkg::KIND_WRITE) |=> !rsp_valid)
      else $error("write transaction produced a response");

   a_request_answered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == plc_pkg::KIND_LOOKUP || req_kind == plc_pkg::KIND_READ))
      |=> rsp_valid)
      else $error("lookup or read transaction got no response");

   a_pal8_index: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == plc_pkg::KIND_LOOKUP && fmt_ff == plc_pkg::FMT_PAL8)
      |=> (rsp_value == {24'h000000, $past(req_index)}))
      else $error("palettized lookup did not return the index");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response strobe after reset");

endmodule
